>>> src/splitmix_random_draw_unit_macros.svh
// Assertion macros for the draw unit.
`ifndef SPLITMIX_RANDOM_DRAW_UNIT_MACROS_SVH
`define SPLITMIX_RANDOM_DRAW_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SRD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SRD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> src/srd_pkg.sv
package srd_pkg;

  localparam logic [63:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB    = 64'h94d049bb133111eb;
  localparam logic [63:0] TestScale  = 64'd1000;

  localparam logic [2:0] ModeRaw     = 3'd0;
  localparam logic [2:0] ModeBelow   = 3'd1;
  localparam logic [2:0] ModeRange   = 3'd2;
  localparam logic [2:0] ModePercent = 3'd3;
  localparam logic [2:0] ModeMille   = 3'd4;
  localparam logic [2:0] ModeSet     = 3'd5;
  localparam logic [2:0] ModeSeed    = 3'd6;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] bound;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [9:0]  chance;
    logic [63:0] seed_value;
    logic [63:0] tick;
    logic [63:0] stream_id;
  } srd_in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        hit;
    logic [63:0] state_out;
  } srd_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture input item
    OP_ADVANCE,   // state += step, x = state
    OP_STEP_VAL,  // x = value + step
    OP_PRE_A,     // mc = x ^ x>>30, clear product
    OP_MUL_A,     // x = x * A (partial product step)
    OP_PRE_B,     // mc = x ^ x>>27, clear product
    OP_MUL_B,
    OP_POST,      // x = x ^ x>>31
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC_SEED,  // acc ^= x
    OP_LOAD_ST,   // state = value (golden if zero)
    OP_FINISH
  } srd_op_e;

  typedef struct packed {
    srd_op_e     op;
    logic [1:0]  sel;   // operand select for OP_STEP_VAL and OP_LOAD_ST
  } srd_cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       div_done;
    logic [2:0] mode;
    logic       skip;   // zero bound or empty range
  } srd_status_t;

endpackage

>>> src/srd_datapath.sv
module srd_datapath
  import srd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srd_cmd_t    cmd_i,
  input  srd_in_t     item_i,
  output srd_status_t stat_o,
  output srd_out_t    res_o
);

  srd_in_t     it_q;
  logic [63:0] state_q, state_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] mc_q, mc_d;     // multiplicand shifted
  logic [63:0] prod_q, prod_d;
  logic [1:0]  mcnt_q, mcnt_d;
  logic        mmode_q, mmode_d;
  logic [63:0] dvsr_q, dvsr_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;   // dividend bits still to shift in
  logic [5:0]  dcnt_q, dcnt_d;

  logic signed [32:0] span;
  logic [64:0] rem_sh, rem_sub;
  logic [15:0] mul_slice;
  logic [63:0] mul_const;
  logic signed [15:0] thr;
  logic [31:0] word;
  logic [63:0] step_src;

  assign span = 33'(it_q.range_high) - 33'(it_q.range_low);
  assign mul_const = mmode_q ? MixMulB : MixMulA;
  assign mul_slice = mul_const[16*mcnt_q +: 16];
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  // threshold can go well below zero; 16 bits hold the full span
  assign thr = (it_q.mode == ModePercent)
             ? 16'sd1000 - $signed(16'd10 * 16'(it_q.chance))
             : 16'sd1000 - $signed(16'(it_q.chance));

  always_comb begin
    case (cmd_i.sel)
      2'd0:    step_src = it_q.tick;
      2'd1:    step_src = it_q.stream_id;
      2'd2:    step_src = it_q.seed_value ^ acc_q;
      default: step_src = x_q;
    endcase
  end

  always_comb begin
    state_d = state_q; x_d = x_q; acc_d = acc_q; mc_d = mc_q; prod_d = prod_q;
    mcnt_d = mcnt_q; mmode_d = mmode_q; dvsr_d = dvsr_q; rem_d = rem_q;
    quo_d = quo_q; dcnt_d = dcnt_q;
    case (cmd_i.op)
      OP_LATCH:    acc_d = '0;
      OP_ADVANCE: begin
        state_d = state_q + GoldenStep;
        x_d = state_q + GoldenStep;
      end
      OP_STEP_VAL: x_d = step_src + GoldenStep;
      OP_PRE_A: begin
        mc_d = x_q ^ (x_q >> 30); prod_d = '0; mcnt_d = '0; mmode_d = 1'b0;
      end
      OP_PRE_B: begin
        mc_d = x_q ^ (x_q >> 27); prod_d = '0; mcnt_d = '0; mmode_d = 1'b1;
      end
      OP_MUL_A, OP_MUL_B: begin
        // 64x16 partial product a cycle
        prod_d = prod_q + (mc_q * {48'd0, mul_slice});
        mc_d = mc_q << 16;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) x_d = prod_q + (mc_q * {48'd0, mul_slice});
      end
      OP_POST:     x_d = x_q ^ (x_q >> 31);
      OP_DIV_INIT: begin
        rem_d = '0; quo_d = x_q[63:32]; dcnt_d = '0;
        case (it_q.mode)
          ModeBelow: dvsr_d = it_q.bound;
          ModeRange: dvsr_d = {31'd0, span};
          default:   dvsr_d = TestScale;
        endcase
      end
      OP_DIV_STEP: begin
        rem_d = rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
        quo_d = quo_q << 1;
        dcnt_d = dcnt_q + 6'd1;
      end
      OP_ACC_SEED: acc_d = acc_q ^ x_q;
      OP_LOAD_ST:  state_d = (step_src == '0) ? GoldenStep : step_src;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GoldenStep;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      mmode_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mcnt_q  <= mcnt_d;
      dcnt_q  <= dcnt_d;
      mmode_q <= mmode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) it_q <= item_i;
    x_q <= x_d; acc_q <= acc_d; mc_q <= mc_d; prod_q <= prod_d;
    dvsr_q <= dvsr_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  always_comb begin
    word = '0;
    res_o.hit = 1'b0;
    case (it_q.mode)
      ModeRaw:   word = x_q[63:32];
      ModeBelow: word = (it_q.bound == '0) ? '0 : rem_q[31:0];
      ModeRange: word = (span <= 0) ? it_q.range_low
                                    : 32'(it_q.range_low) + rem_q[31:0];
      ModePercent, ModeMille: res_o.hit = $signed({6'd0, rem_q[9:0]}) >= thr;
      default: ;
    endcase
    res_o.result_word = word;
    res_o.state_out = state_q;
  end

  assign stat_o.mul_done = (mcnt_q == 2'd3);
  assign stat_o.div_done = (dcnt_q == 6'd31);
  assign stat_o.mode = it_q.mode;
  assign stat_o.skip = ((it_q.mode == ModeBelow) && (it_q.bound == '0)) ||
                       ((it_q.mode == ModeRange) && (span <= 0));

endmodule

>>> src/srd_ctrl.sv
module srd_ctrl
  import srd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  srd_status_t stat_i,
  output srd_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADV, S_PRE_A, S_MUL_A, S_PRE_B, S_MUL_B, S_POST,
    S_DIV_INIT, S_DIV, S_SEED_DONE, S_SEED_LOAD, S_OUT
  } state_e;

  state_e st_q;
  logic [1:0] phase_q;   // seeding mix index: tick, stream, final
  logic       out_q;

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_q;

  always_comb begin
    cmd_o.op = OP_NONE;
    cmd_o.sel = 2'd3;
    case (st_q)
      S_IDLE:   if (in_valid_i) cmd_o.op = OP_LATCH;
      S_DECODE: begin
        if (stat_i.mode == ModeSet) begin
          cmd_o.op = OP_LOAD_ST; cmd_o.sel = 2'd2;
        end else if (stat_i.mode == ModeSeed) begin
          cmd_o.op = OP_STEP_VAL; cmd_o.sel = 2'd0;
        end
      end
      S_ADV:      cmd_o.op = OP_ADVANCE;
      S_PRE_A:    cmd_o.op = OP_PRE_A;
      S_MUL_A:    cmd_o.op = OP_MUL_A;
      S_PRE_B:    cmd_o.op = OP_PRE_B;
      S_MUL_B:    cmd_o.op = OP_MUL_B;
      S_POST:     cmd_o.op = OP_POST;
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_SEED_DONE: begin
        if (phase_q == 2'd2) begin
          cmd_o.op = OP_LOAD_ST;
        end else begin
          cmd_o.op = OP_ACC_SEED;
        end
      end
      // load stream, then seed xor both mixes, as the next mix operand
      S_SEED_LOAD: begin
        cmd_o.op = OP_STEP_VAL; cmd_o.sel = phase_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      phase_q <= '0;
      out_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: if (in_valid_i) st_q <= S_DECODE;
        S_DECODE: begin
          phase_q <= '0;
          if (stat_i.mode == ModeSeed) st_q <= S_PRE_A;
          else if (stat_i.mode > ModeSeed || stat_i.mode == ModeSet || stat_i.skip) begin
            st_q <= S_OUT; out_q <= 1'b1;
          end else st_q <= S_ADV;
        end
        S_ADV:   st_q <= S_PRE_A;
        S_PRE_A: st_q <= S_MUL_A;
        S_MUL_A: if (stat_i.mul_done) st_q <= S_PRE_B;
        S_PRE_B: st_q <= S_MUL_B;
        S_MUL_B: if (stat_i.mul_done) st_q <= S_POST;
        S_POST: begin
          if (stat_i.mode == ModeSeed) st_q <= S_SEED_DONE;
          else if (stat_i.mode == ModeRaw) begin
            st_q <= S_OUT; out_q <= 1'b1;
          end else st_q <= S_DIV_INIT;
        end
        S_DIV_INIT: st_q <= S_DIV;
        S_DIV: if (stat_i.div_done) begin
          st_q <= S_OUT; out_q <= 1'b1;
        end
        S_SEED_DONE: begin
          // tick mixed, then stream, then final mix loads state
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd2) begin
            st_q <= S_OUT; out_q <= 1'b1;
          end else st_q <= S_SEED_LOAD;
        end
        S_SEED_LOAD: st_q <= S_PRE_A;
        S_OUT: if (out_ready_i) begin
          st_q <= S_IDLE; out_q <= 1'b0;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/splitmix_random_draw_unit.sv
// SplitMix64 draw unit. One word at a time: in_ready_o is high only while the
// unit is idle, and the result word stays on out_data_o until taken. A raw draw
// runs two 64x64 multiplies, each as four 64x16 partial product steps; bounded,
// range, percent and mille draws add a restoring modulo (setup plus 32 steps);
// set state, zero bound, empty range and the unused mode skip the mix and go
// straight to out_valid_o; deterministic seed runs three full mixes. in_ready_o
// rises again as soon as a taken result returns the unit to idle.
`include "splitmix_random_draw_unit_macros.svh"
module splitmix_random_draw_unit
  import srd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  srd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output srd_out_t out_data_o
);

  srd_cmd_t    cmd;
  srd_status_t stat;

  srd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  srd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i), .stat_o(stat),
    .res_o(out_data_o)
  );

  `SRD_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `SRD_ASSERT_NEXT(a_take_frees, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
  `SRD_ASSERT_IMPL(a_state_nz_load, clk_i, rst_ni, out_valid_o && (stat.mode == ModeSet),
                   out_data_o.state_out != '0)

endmodule
